// File: src/lookahead_peak_limiter_defines.svh
// Assertion macros shared by the lookahead peak limiter RTL.
`ifndef LOOKAHEAD_PEAK_LIMITER_DEFINES_SVH
`define LOOKAHEAD_PEAK_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define LPL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lookahead peak limiter check failed");
// Check that a condition implies a property outside reset.
`define LPL_ASSERT_IMP(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("lookahead peak limiter check failed");
`else
`define LPL_ASSERT(label, prop)
`define LPL_ASSERT_IMP(label, cond, prop)
`endif

`endif

// File: src/lpl_pkg.sv
// Types and constants of the lookahead peak limiter.
package lpl_pkg;

   localparam int CHANNELS    = 2;
   localparam int SAMPLE_BITS = 24;
   localparam int PEAK_BITS   = 23;
   localparam int GAIN_BITS   = 24;
   localparam int CEIL_BITS   = 23;
   localparam int COEF_BITS   = 25;
   localparam int WLEN_BITS   = 9;
   localparam int CSR_BITS    = 25;
   localparam int CSR_IDX_BITS = 2;
   localparam int GAIN_FRAC   = 23;
   localparam int COEF_FRAC   = 24;
   localparam int ENV_PROD_BITS = GAIN_BITS + COEF_BITS;
   localparam int MAG_PROD_BITS = 2 * SAMPLE_BITS;
   localparam int DIV_CNT_BITS  = $clog2(PEAK_BITS + 1);

   localparam logic [GAIN_BITS-1:0] GAIN_UNITY    = 24'd8388608;
   localparam logic [COEF_BITS-1:0] COEF_ONE      = 25'd16777216;
   localparam logic [WLEN_BITS-1:0] WINDOW_MIN    = 9'd16;
   localparam logic [PEAK_BITS-1:0] PEAK_CAP      = 23'd8388607;
   localparam logic [CEIL_BITS-1:0] CEIL_RESET    = 23'd4194304;
   localparam logic [COEF_BITS-1:0] COEF_RESET    = 25'd1000;
   localparam logic [WLEN_BITS-1:0] WINDOW_RESET  = 9'd144;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLE  = 2'd0,
      CSR_CEILING = 2'd1,
      CSR_RELEASE = 2'd2,
      CSR_WINDOW  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_ENV_MUL,
      ST_ENV_ADD,
      ST_SCALE,
      ST_ROUND,
      ST_DONE
   } state_type;

endpackage

// File: src/lpl_if.sv
// Stream interfaces for input frames and limited result frames.
interface lpl_req_if;
   logic                valid;
   logic                ready;
   lpl_pkg::sample_type sample_left;
   lpl_pkg::sample_type sample_right;

   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

interface lpl_rsp_if;
   logic                                valid;
   logic                                ready;
   lpl_pkg::sample_type                 limited_left;
   lpl_pkg::sample_type                 limited_right;
   logic [lpl_pkg::GAIN_BITS-1:0]       gain_now;

   modport source (output valid, output limited_left, output limited_right,
                   output gain_now, input ready);
   modport sink   (input valid, input limited_left, input limited_right,
                   input gain_now, output ready);
endinterface

// File: src/lpl_mem.sv
// Delay memory and peak memory, one shared write port and one read port each.
module lpl_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [AW-1:0]                                   wr_addr,
   input  logic [lpl_pkg::CHANNELS*lpl_pkg::SAMPLE_BITS-1:0] wr_delay,
   input  logic [lpl_pkg::PEAK_BITS-1:0]                   wr_peak,
   input  logic [AW-1:0]                                   peak_rd_addr,
   output logic [lpl_pkg::PEAK_BITS-1:0]                   peak_rd_data,
   input  logic [AW-1:0]                                   delay_rd_addr,
   output logic [lpl_pkg::CHANNELS*lpl_pkg::SAMPLE_BITS-1:0] delay_rd_data
);
   import lpl_pkg::*;

   logic [CHANNELS*SAMPLE_BITS-1:0] delay_mem [DEPTH];
   logic [PEAK_BITS-1:0]            peak_mem  [DEPTH];
   logic [CHANNELS*SAMPLE_BITS-1:0] delay_rd_ff;
   logic [PEAK_BITS-1:0]            peak_rd_ff;

   // Frame and peak are written together at the same ring position.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         delay_mem[wr_addr] <= wr_delay;
         peak_mem[wr_addr]  <= wr_peak;
      end
      peak_rd_ff  <= peak_mem[peak_rd_addr];
      delay_rd_ff <= delay_mem[delay_rd_addr];
   end

   assign peak_rd_data  = peak_rd_ff;
   assign delay_rd_data = delay_rd_ff;

endmodule

// File: src/lpl_div.sv
// Restoring divider for the required gain, one quotient bit per cycle.
module lpl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpl_pkg::CEIL_BITS-1:0] ceiling,
   input  logic [lpl_pkg::PEAK_BITS-1:0] divisor,
   output logic                          done,
   output logic [lpl_pkg::PEAK_BITS-1:0] quotient
);
   import lpl_pkg::*;

   logic [PEAK_BITS:0]      rem_ff, rem_in, trial;
   logic [PEAK_BITS-1:0]    quot_ff, quot_in;
   logic [PEAK_BITS-1:0]    div_ff, div_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   // The ceiling is below the divisor, so the integer quotient bits are zero
   // and only the fraction bits remain to be produced.
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[PEAK_BITS-1:0], 1'b0};
      if (start) begin
         rem_in  = {1'b0, ceiling};
         quot_in = '0;
         div_in  = divisor;
         cnt_in  = DIV_CNT_BITS'(PEAK_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = trial - {1'b0, div_ff};
            quot_in = {quot_ff[PEAK_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[PEAK_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: src/lookahead_peak_limiter.sv
// Top level of the lookahead peak limiter: registers, sequencer and gain datapath.
//
// The limiter takes one oversampled stereo frame per transfer and returns one
// limited frame, delayed by N-1 frames where N is the window length clamped to
// [16, WINDOW_MAX]. With limiting enabled a frame passes through the peak scan,
// which reads the peak memory one entry per cycle, the bit-serial gain divider
// when the window peak exceeds the ceiling, and then the envelope update, output
// scaling, result hand-off and return to idle; the divider is skipped when no
// division is needed. With limiting disabled a frame passes through unchanged.
// After reset a clearing pass zeroes both memories; no frame is taken during it,
// while register writes are taken at any time.
// Registers should be written only while no frame is in flight.
`include "lookahead_peak_limiter_defines.svh"

module lookahead_peak_limiter #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   lpl_req_if.sink                          req_if,
   lpl_rsp_if.source                        rsp_if,
   input  logic                             csr_wr_en,
   input  logic [lpl_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [lpl_pkg::CSR_BITS-1:0]     csr_wr_data
);
   import lpl_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int NW = $clog2(WINDOW_MAX + 1);

   // Configuration registers.
   logic                 enable_ff;
   logic [CEIL_BITS-1:0] ceiling_ff;
   logic [COEF_BITS-1:0] coef_ff;
   logic [WLEN_BITS-1:0] window_ff;

   // Sequencer and datapath state.
   state_type             state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [NW-1:0]         scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [PEAK_BITS-1:0]  wmax_ff, wmax_in;
   logic [GAIN_BITS-1:0]  env_ff, env_in;
   logic [GAIN_BITS-1:0]  req_gain_ff, req_gain_in;
   logic [ENV_PROD_BITS-1:0] prod_ff, prod_in;
   logic [MAG_PROD_BITS-1:0] mag_ff [CHANNELS];
   logic [MAG_PROD_BITS-1:0] mag_in [CHANNELS];
   logic                  neg_ff [CHANNELS];
   logic                  neg_in [CHANNELS];
   sample_type            res_ff [CHANNELS];
   sample_type            res_in [CHANNELS];
   logic                  rsp_valid_ff, rsp_valid_in;
   sample_type            rsp_left_ff, rsp_left_in;
   sample_type            rsp_right_ff, rsp_right_in;
   logic [GAIN_BITS-1:0]  rsp_gain_ff, rsp_gain_in;

   // Combinational helpers.
   sample_type            smp_c [CHANNELS];
   sample_type            dly_c [CHANNELS];
   logic [SAMPLE_BITS-1:0] abs_c [CHANNELS];
   logic [SAMPLE_BITS-1:0] dabs_c [CHANNELS];
   logic [SAMPLE_BITS-1:0] peak_wide_c;
   logic [PEAK_BITS-1:0]  peak_c;
   logic [NW-1:0]         n_c;
   logic [AW-1:0]         pos_c;
   logic [NW-1:0]         pos_inc_c;
   logic [AW-1:0]         pos_next_c;
   logic [COEF_BITS-1:0]  coef_c;
   logic [MAG_PROD_BITS-1:0] rnd_c [CHANNELS];
   logic [SAMPLE_BITS:0]  r_c [CHANNELS];
   logic [CEIL_BITS-1:0]  rc_c [CHANNELS];

   // Memory and divider connections.
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [CHANNELS*SAMPLE_BITS-1:0] mem_wdelay;
   logic [PEAK_BITS-1:0]  mem_wpeak;
   logic [PEAK_BITS-1:0]  peak_rd;
   logic [CHANNELS*SAMPLE_BITS-1:0] delay_rd;
   logic                  div_start;
   logic                  div_done;
   logic [PEAK_BITS-1:0]  div_quot;
   logic                  req_ready;

   lpl_mem #(.DEPTH(WINDOW_MAX), .AW(AW)) u_mem (
      .clock         (clock),
      .wr_en         (mem_we),
      .wr_addr       (mem_waddr),
      .wr_delay      (mem_wdelay),
      .wr_peak       (mem_wpeak),
      .peak_rd_addr  (scan_ff[AW-1:0]),
      .peak_rd_data  (peak_rd),
      .delay_rd_addr (pos_ff),
      .delay_rd_data (delay_rd)
   );

   lpl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .ceiling  (ceiling_ff),
      .divisor  (wmax_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         ceiling_ff <= CEIL_RESET;
         coef_ff    <= COEF_RESET;
         window_ff  <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:  enable_ff  <= csr_wr_data[0];
            CSR_CEILING: ceiling_ff <= csr_wr_data[CEIL_BITS-1:0];
            CSR_RELEASE: coef_ff    <= csr_wr_data[COEF_BITS-1:0];
            CSR_WINDOW:  window_ff  <= csr_wr_data[WLEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Frame peak, window length, ring position, delayed samples, rounding, release clamp.
   always_comb begin
      smp_c[0] = req_if.sample_left;
      smp_c[1] = req_if.sample_right;
      peak_wide_c = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         abs_c[ch] = smp_c[ch][SAMPLE_BITS-1] ? (~smp_c[ch] + 1'b1) : smp_c[ch];
         if (abs_c[ch] > peak_wide_c) begin
            peak_wide_c = abs_c[ch];
         end
         dly_c[ch]  = delay_rd[ch*SAMPLE_BITS +: SAMPLE_BITS];
         dabs_c[ch] = dly_c[ch][SAMPLE_BITS-1] ? (~dly_c[ch] + 1'b1) : dly_c[ch];
         rnd_c[ch]  = mag_ff[ch] + (MAG_PROD_BITS'(1) << (GAIN_FRAC - 1));
         r_c[ch]    = rnd_c[ch][GAIN_FRAC +: SAMPLE_BITS+1];
         rc_c[ch]   = (r_c[ch] > {2'b00, ceiling_ff}) ? ceiling_ff
                                                      : r_c[ch][CEIL_BITS-1:0];
      end
      peak_c = (peak_wide_c > {1'b0, PEAK_CAP}) ? PEAK_CAP : peak_wide_c[PEAK_BITS-1:0];

      if (window_ff < WINDOW_MIN) begin
         n_c = NW'(WINDOW_MIN);
      end else if (window_ff > WINDOW_MAX) begin
         n_c = NW'(WINDOW_MAX);
      end else begin
         n_c = NW'(window_ff);
      end
      pos_c      = (pos_ff >= n_c) ? '0 : pos_ff;
      pos_inc_c  = NW'(pos_c) + 1'b1;
      pos_next_c = (pos_inc_c == n_c) ? '0 : pos_inc_c[AW-1:0];
      coef_c     = (coef_ff > COEF_ONE) ? COEF_ONE : coef_ff;
   end

   // Sequencer: next state, memory accesses and datapath updates.
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      pos_in      = pos_ff;
      n_in        = n_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      wmax_in     = wmax_ff;
      env_in      = env_ff;
      req_gain_in = req_gain_ff;
      prod_in     = prod_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_waddr   = pos_c;
      mem_wdelay  = {req_if.sample_right, req_if.sample_left};
      mem_wpeak   = peak_c;
      div_start   = 1'b0;
      req_ready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_gain_in  = rsp_gain_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_ff;
            mem_wdelay = '0;
            mem_wpeak  = '0;
            if (clr_ff == AW'(WINDOW_MAX - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               if (enable_ff) begin
                  mem_we   = 1'b1;
                  n_in     = n_c;
                  pos_in   = pos_next_c;
                  scan_in  = '0;
                  wmax_in  = '0;
                  state_in = ST_SCAN;
               end else begin
                  res_in   = smp_c;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // One peak read per cycle; the compare on the read data follows in the next cycle.
            if (scan_ff < n_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff && (peak_rd > wmax_ff)) begin
               wmax_in = peak_rd;
            end
            if ((scan_ff == n_ff) && !pend_ff) begin
               if (wmax_ff > ceiling_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  req_gain_in = GAIN_UNITY;
                  state_in    = ST_ENV_MUL;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               req_gain_in = {1'b0, div_quot};
               state_in    = ST_ENV_MUL;
            end
         end
         ST_ENV_MUL: begin
            // Instant attack, otherwise start the release step.
            if (req_gain_ff < env_ff) begin
               env_in   = req_gain_ff;
               state_in = ST_SCALE;
            end else begin
               prod_in  = {{COEF_BITS{1'b0}}, req_gain_ff - env_ff}
                        * {{GAIN_BITS{1'b0}}, coef_c};
               state_in = ST_ENV_ADD;
            end
         end
         ST_ENV_ADD: begin
            env_in   = env_ff + GAIN_BITS'((prod_ff + ((ENV_PROD_BITS'(1) << COEF_FRAC)
                                           - 1'b1)) >> COEF_FRAC);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               neg_in[ch] = dly_c[ch][SAMPLE_BITS-1];
               mag_in[ch] = {{SAMPLE_BITS{1'b0}}, dabs_c[ch]}
                          * {{(MAG_PROD_BITS-GAIN_BITS){1'b0}}, env_ff};
            end
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
               res_in[ch] = neg_ff[ch] ? -sample_type'({1'b0, rc_c[ch]})
                                       : sample_type'({1'b0, rc_c[ch]});
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_ff[0];
               rsp_right_in = res_ff[1];
               rsp_gain_in  = env_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         env_ff       <= GAIN_UNITY;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_ff       <= pos_in;
         env_ff       <= env_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      scan_ff      <= scan_in;
      wmax_ff      <= wmax_in;
      req_gain_ff  <= req_gain_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_gain_ff  <= rsp_gain_in;
   end

   assign req_if.ready         = req_ready;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.limited_left  = rsp_left_ff;
   assign rsp_if.limited_right = rsp_right_ff;
   assign rsp_if.gain_now      = rsp_gain_ff;

   // Checks on the sequencer and the envelope.
   `LPL_ASSERT(a_env_not_above_unity, env_ff <= GAIN_UNITY)
   `LPL_ASSERT_IMP(a_div_done_in_div, div_done, state_ff == ST_DIV)
   `LPL_ASSERT_IMP(a_scan_in_window, state_ff == ST_SCAN, scan_ff <= n_ff)
   `LPL_ASSERT_IMP(a_enabled_frame_scans, req_if.valid && req_ready && enable_ff, ##1 state_ff == ST_SCAN)

endmodule
